// ===== rtl/core/button_debounce_repeat_assert.svh =====
// Assertion macros used by the checker of the button debouncer.
// No dependencies; include by bare file name.
`ifndef BUTTON_DEBOUNCE_REPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_REPEAT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define BDR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("button debounce assertion failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define BDR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("button debounce assertion failed");

`endif

// ===== rtl/core/bdr_pkg.sv =====
// Shared types and constants of the button debouncer with auto-repeat.
// No dependencies; imported by the interfaces, the top level and the checker.
package bdr_pkg;

   localparam int DEF_NUM_BUTTONS  = 8;
   localparam int DEF_HISTORY_BITS = 64;
   localparam int PIN_BITS         = 8;
   localparam int MAX_EVENTS       = 8;
   localparam int TICK_BITS        = 16;
   localparam int FIFO_DEPTH       = 4 * MAX_EVENTS;

   // configuration register indexes
   localparam logic [1:0] CSR_DEBOUNCE_SAMPLES = 2'd0;
   localparam logic [1:0] CSR_REPEAT_DELAY     = 2'd1;
   localparam logic [1:0] CSR_REPEAT_INTERVAL  = 2'd2;

   localparam logic [6:0]  RST_DEBOUNCE_SAMPLES = 7'd5;
   localparam logic [15:0] RST_REPEAT_DELAY     = 16'd500;
   localparam logic [15:0] RST_REPEAT_INTERVAL  = 16'd100;

   // event codes
   localparam logic [1:0] EV_RELEASE = 2'd0;
   localparam logic [1:0] EV_PRESS   = 2'd1;
   localparam logic [1:0] EV_REPEAT  = 2'd2;
   localparam logic [1:0] EV_UNUSED  = 2'd3;

   typedef struct packed {
      logic [2:0] button_index;
      logic [1:0] event_kind;
      logic       last_of_tick;
   } bdr_event_type;

endpackage

// ===== rtl/core/bdr_if.sv =====
// Valid/ready channel interfaces of the button debouncer: poll ticks in,
// button events out. Depends on bdr_pkg.
interface bdr_req_if import bdr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIN_BITS-1:0] pin_levels_n;

   modport source (output valid, output pin_levels_n, input ready);
   modport sink   (input valid, input pin_levels_n, output ready);
endinterface

interface bdr_rsp_if import bdr_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] button_index;
   logic [1:0] event_kind;
   logic       last_of_tick;

   modport source (output valid, output button_index, output event_kind,
                   output last_of_tick, input ready);
   modport sink   (input valid, input button_index, input event_kind,
                   input last_of_tick, output ready);
endinterface

// ===== rtl/core/button_debounce_repeat.sv =====
// Top level of the button debouncer with auto-repeat.
// Depends on bdr_pkg and the channel interfaces in bdr_if.sv.
//
// Each poll tick visits all buttons in turn: the per-button records (sample
// history, held flag, hold counter) sit in one state memory that is read,
// updated and written back one button per cycle, so the memory port sets the
// rate. A new tick is taken in the cycle the previous one issues its last
// button, so ticks run back to back. Events go through a 32-entry queue and
// leave one per cycle while ready is high; a tick is accepted only while the
// queue has at least 16 free entries. Events of a tick come out in ascending
// button order, at most eight per tick, the final one flagged by last_of_tick.
module button_debounce_repeat
   import bdr_pkg::*;
#(
   parameter int NUM_BUTTONS  = DEF_NUM_BUTTONS,
   parameter int HISTORY_BITS = DEF_HISTORY_BITS
) (
   input  logic        clock,
   input  logic        reset,
   bdr_req_if.sink     req_chan,
   bdr_rsp_if.source   rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int BW        = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int IDXW      = (BW > 4) ? BW : 4;
   localparam int EW        = HISTORY_BITS + 1 + TICK_BITS;
   localparam int FPW       = $clog2(FIFO_DEPTH);
   localparam int FCW       = FPW + 1;
   localparam int ECW       = $clog2(MAX_EVENTS + 1);
   localparam logic [BW-1:0]  LAST_BTN    = BW'(NUM_BUTTONS - 1);
   localparam logic [FCW-1:0] FIFO_THRESH = FCW'(FIFO_DEPTH - 2 * MAX_EVENTS);

   // configuration
   logic [6:0]           debounce_ff;
   logic [TICK_BITS-1:0] delay_ff;
   logic [TICK_BITS-1:0] interval_ff;

   // read stage
   logic                busy_ff, busy_in;
   logic [BW-1:0]       btn_ff, btn_in;
   logic [PIN_BITS-1:0] levels_ff, levels_in;
   logic                accept;
   logic                rd_bit;
   logic [IDXW-1:0]     rd_btn_wide;

   // state memory
   logic [EW-1:0]          state_mem [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] written_ff, written_in;
   logic [EW-1:0]          rd_data_ff;
   logic                   rd_valid_ff;

   // update stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [BW-1:0]        s1_btn_ff, s1_btn_in;
   logic                 s1_bit_ff, s1_bit_in;
   logic [IDXW-1:0]      s1_btn_wide;
   logic                 s1_last;
   logic [EW-1:0]        wr_data;
   logic [HISTORY_BITS-1:0] hist_old, hist_new, dmask, win;
   logic                 held_old, held_new;
   logic [TICK_BITS-1:0] ticks_old, ticks_new, ticks_inc, reload;
   logic                 kind_valid;
   logic [1:0]           kind;
   logic                 take;
   logic [6:0]           win_len;

   // event sequencing
   logic [ECW-1:0]  ev_cnt_ff, ev_cnt_in, ev_base;
   logic            pend_valid_ff, pend_valid_in;
   bdr_event_type   pend_ff, pend_in;
   bdr_event_type   new_ev, push_d0, push_d1;
   logic [1:0]      push_cnt;

   // event queue
   bdr_event_type   fifo_mem [FIFO_DEPTH];
   logic [FPW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FCW-1:0]  count_ff, count_in;
   logic            pop;
   bdr_event_type   head;

   // read stage and handshake
   always_comb begin
      req_chan.ready = (!busy_ff || btn_ff == LAST_BTN) && (count_ff <= FIFO_THRESH);
      accept         = req_chan.valid && req_chan.ready;
      levels_in      = accept ? req_chan.pin_levels_n : levels_ff;
      busy_in        = accept || (busy_ff && btn_ff != LAST_BTN);
      if (accept || !busy_ff || btn_ff == LAST_BTN) begin
         btn_in = '0;
      end else begin
         btn_in = btn_ff + 1'b1;
      end
      rd_btn_wide = IDXW'(btn_ff);
      // buttons beyond the pin word read as released
      rd_bit      = (rd_btn_wide < IDXW'(PIN_BITS)) ? ~levels_ff[rd_btn_wide[2:0]] : 1'b0;
      s1_valid_in = busy_ff;
      s1_btn_in   = btn_ff;
      s1_bit_in   = rd_bit;
   end

   // window mask and repeat reload from configuration
   always_comb begin
      if (debounce_ff == 7'd0) begin
         win_len = 7'd1;
      end else if (debounce_ff > 7'(HISTORY_BITS)) begin
         win_len = 7'(HISTORY_BITS);
      end else begin
         win_len = debounce_ff;
      end
      for (int k = 0; k < HISTORY_BITS; k++) begin
         dmask[k] = (7'(k) < win_len);
      end
      reload = (interval_ff > delay_ff) ? '0 : delay_ff - interval_ff;
   end

   // update stage: debounce and hold counting for one button
   always_comb begin
      if (rd_valid_ff) begin
         hist_old  = rd_data_ff[EW-1 -: HISTORY_BITS];
         held_old  = rd_data_ff[TICK_BITS];
         ticks_old = rd_data_ff[TICK_BITS-1:0];
      end else begin
         hist_old  = HISTORY_BITS'(2);
         held_old  = 1'b0;
         ticks_old = '0;
      end
      hist_new   = HISTORY_BITS'({hist_old, s1_bit_ff});
      win        = hist_new & dmask;
      held_new   = held_old;
      ticks_new  = ticks_old;
      kind_valid = 1'b0;
      kind       = EV_RELEASE;
      ticks_inc  = (ticks_old != '1) ? ticks_old + 1'b1 : ticks_old;
      if (win == '0) begin
         if (held_old) begin
            held_new   = 1'b0;
            kind_valid = 1'b1;
            kind       = EV_RELEASE;
         end
      end else if (win == dmask) begin
         if (held_old) begin
            ticks_new = ticks_inc;
            if (ticks_inc >= delay_ff) begin
               ticks_new  = reload;
               kind_valid = 1'b1;
               kind       = EV_REPEAT;
            end
         end else begin
            held_new   = 1'b1;
            ticks_new  = '0;
            kind_valid = 1'b1;
            kind       = EV_PRESS;
         end
      end
      wr_data = {hist_new, held_new, ticks_new};
   end

   // event ordering: hold one event back until the next one or the tick end
   always_comb begin
      s1_btn_wide  = IDXW'(s1_btn_ff);
      s1_last      = (s1_btn_ff == LAST_BTN);
      ev_base      = (s1_btn_ff == '0) ? '0 : ev_cnt_ff;
      take         = s1_valid_ff && kind_valid && (ev_base < ECW'(MAX_EVENTS));
      new_ev.button_index = s1_btn_wide[2:0];
      new_ev.event_kind   = kind;
      new_ev.last_of_tick = 1'b0;
      ev_cnt_in     = s1_valid_ff ? ev_base + ECW'(take) : ev_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      push_cnt      = 2'd0;
      push_d0       = pend_ff;
      push_d1       = new_ev;
      if (s1_valid_ff) begin
         if (!s1_last) begin
            if (take) begin
               push_cnt      = pend_valid_ff ? 2'd1 : 2'd0;
               pend_valid_in = 1'b1;
               pend_in       = new_ev;
            end
         end else begin
            pend_valid_in = 1'b0;
            if (take) begin
               if (pend_valid_ff) begin
                  push_d1.last_of_tick = 1'b1;
                  push_cnt = 2'd2;
               end else begin
                  push_d0 = new_ev;
                  push_d0.last_of_tick = 1'b1;
                  push_cnt = 2'd1;
               end
            end else if (pend_valid_ff) begin
               push_d0.last_of_tick = 1'b1;
               push_cnt = 2'd1;
            end
         end
      end
   end

   // event queue pointers and output
   always_comb begin
      head                  = fifo_mem[rd_ptr_ff];
      rsp_chan.valid        = (count_ff != '0);
      rsp_chan.button_index = head.button_index;
      rsp_chan.event_kind   = head.event_kind;
      rsp_chan.last_of_tick = head.last_of_tick;
      pop       = rsp_chan.valid && rsp_chan.ready;
      wr_ptr_in = wr_ptr_ff + FPW'(push_cnt);
      rd_ptr_in = rd_ptr_ff + FPW'(pop);
      count_in  = count_ff + FCW'(push_cnt) - FCW'(pop);
      written_in = written_ff;
      if (s1_valid_ff) begin
         written_in[s1_btn_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= RST_DEBOUNCE_SAMPLES;
         delay_ff      <= RST_REPEAT_DELAY;
         interval_ff   <= RST_REPEAT_INTERVAL;
         busy_ff       <= 1'b0;
         btn_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         written_ff    <= '0;
         ev_cnt_ff     <= '0;
         pend_valid_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEBOUNCE_SAMPLES: debounce_ff <= csr_wdata[6:0];
               CSR_REPEAT_DELAY:     delay_ff    <= csr_wdata;
               CSR_REPEAT_INTERVAL:  interval_ff <= csr_wdata;
               default: ;
            endcase
         end
         busy_ff       <= busy_in;
         btn_ff        <= btn_in;
         s1_valid_ff   <= s1_valid_in;
         written_ff    <= written_in;
         ev_cnt_ff     <= ev_cnt_in;
         pend_valid_ff <= pend_valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
      s1_btn_ff <= s1_btn_in;
      s1_bit_ff <= s1_bit_in;
      pend_ff   <= pend_in;
   end

   // state memory: write back the update, read the next button with bypass
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         state_mem[s1_btn_ff] <= wr_data;
      end
      if (s1_valid_ff && s1_btn_ff == btn_ff) begin
         rd_data_ff  <= wr_data;
         rd_valid_ff <= 1'b1;
      end else begin
         rd_data_ff  <= state_mem[btn_ff];
         rd_valid_ff <= written_ff[btn_ff];
      end
   end

   // event queue storage
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         fifo_mem[wr_ptr_ff] <= push_d0;
      end
      if (push_cnt == 2'd2) begin
         fifo_mem[wr_ptr_ff + 1'b1] <= push_d1;
      end
   end

endmodule

// ===== rtl/core/bdr_checker.sv =====
// Port-level checker of the button debouncer, bound to the top level.
// Depends on bdr_pkg and button_debounce_repeat_assert.svh.
`include "button_debounce_repeat_assert.svh"

module bdr_checker
   import bdr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_button_index,
   input logic [1:0] rsp_event_kind,
   input logic       rsp_last_of_tick
);

   // a stalled event holds its fields
   `BDR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_button_index) && $stable(rsp_event_kind) && $stable(rsp_last_of_tick))

   // only release, press or repeat ever leaves the block
   `BDR_ASSERT_IMP(a_kind_legal, clock, reset, rsp_valid, rsp_event_kind != EV_UNUSED)

   // reset empties the event queue
   `BDR_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind button_debounce_repeat bdr_checker u_bdr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_button_index (rsp_chan.button_index),
   .rsp_event_kind   (rsp_chan.event_kind),
   .rsp_last_of_tick (rsp_chan.last_of_tick)
);
